// ===== rtl/core/keypad_debounce_hold_tracker_defines.svh =====
// Assertion macros used by the checker file.
`ifndef KEYPAD_DEBOUNCE_HOLD_TRACKER_DEFINES_SVH
`define KEYPAD_DEBOUNCE_HOLD_TRACKER_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define KDHT_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("kdht assertion failed");

// Next-cycle implication.
`define KDHT_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("kdht assertion failed");

`endif

// ===== rtl/core/kdht_pkg.sv =====
`default_nettype none
package kdht_pkg;

   localparam int KDHT_MAX_ROWS  = 8;
   localparam int KDHT_MAX_COLS  = 16;
   localparam int KDHT_TIME_BITS = 32;

   localparam int KDHT_CSR_DATA_W = 24;
   localparam int KDHT_CSR_IDX_W  = 2;

   localparam logic [19:0] KDHT_DEBOUNCE_RESET = 20'd5000;
   localparam logic [23:0] KDHT_HOLD_RESET     = 24'd500000;
   localparam logic [3:0]  KDHT_ROWS_RESET     = 4'd8;
   localparam logic [4:0]  KDHT_COLS_RESET     = 5'd16;

   typedef enum logic [KDHT_CSR_IDX_W-1:0] {
      CSR_DEBOUNCE_TIME = 2'd0,
      CSR_HOLD_TIME     = 2'd1,
      CSR_ROWS_IN_USE   = 2'd2,
      CSR_COLS_IN_USE   = 2'd3
   } kdht_csr_index_type;

   typedef enum logic [2:0] {
      PH_IDLE        = 3'd0,
      PH_DEB_PRESS   = 3'd1,
      PH_PRESSED     = 3'd2,
      PH_HOLDING     = 3'd3,
      PH_DEB_RELEASE = 3'd4
   } kdht_phase_type;

   typedef struct packed {
      logic [19:0] debounce_time;
      logic [23:0] hold_time;
      logic [3:0]  rows_in_use;
      logic [4:0]  cols_in_use;
   } kdht_cfg_type;

   typedef struct packed {
      logic [2:0] key_phase;
      logic       is_down;
      logic       is_holding;
      logic       press_event;
      logic       release_event;
   } kdht_flags_type;

endpackage
`default_nettype wire

// ===== rtl/core/kdht_csr.sv =====
`default_nettype none
module kdht_csr import kdht_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_wr_en,
   input  wire logic [KDHT_CSR_IDX_W-1:0]  csr_index,
   input  wire logic [KDHT_CSR_DATA_W-1:0] csr_data,
   output kdht_cfg_type                    cfg
);

   kdht_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (kdht_csr_index_type'(csr_index))
            CSR_DEBOUNCE_TIME: cfg_in.debounce_time = csr_data[19:0];
            CSR_HOLD_TIME:     cfg_in.hold_time     = csr_data[23:0];
            CSR_ROWS_IN_USE:   cfg_in.rows_in_use   = csr_data[3:0];
            CSR_COLS_IN_USE:   cfg_in.cols_in_use   = csr_data[4:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_time <= KDHT_DEBOUNCE_RESET;
         cfg_ff.hold_time     <= KDHT_HOLD_RESET;
         cfg_ff.rows_in_use   <= KDHT_ROWS_RESET;
         cfg_ff.cols_in_use   <= KDHT_COLS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ===== rtl/core/kdht_table.sv =====
`default_nettype none
module kdht_table import kdht_pkg::*; #(
   parameter int DEPTH  = KDHT_MAX_ROWS * KDHT_MAX_COLS,
   parameter int IDX_W  = $clog2(KDHT_MAX_ROWS * KDHT_MAX_COLS),
   parameter int DATA_W = 3 + 2 * KDHT_TIME_BITS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              rd_en,
   input  wire logic [IDX_W-1:0]  rd_idx,
   output      logic [DATA_W-1:0] rd_data,
   output      logic              rd_valid,
   input  wire logic              wr_en,
   input  wire logic [IDX_W-1:0]  wr_idx,
   input  wire logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]  vld_ff;
   logic [DATA_W-1:0] rd_data_ff;
   logic              rd_valid_ff;
   logic              wr_hit;

   // a write landing on the same edge as the read is forwarded
   assign wr_hit = wr_en && (wr_idx == rd_idx);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= wr_hit ? wr_data : mem[rd_idx];
      end
   end

   // per-entry valid: an entry never written reads as idle
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_idx] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= wr_hit | vld_ff[rd_idx];
         end
      end
   end

   assign rd_data  = rd_data_ff;
   assign rd_valid = rd_valid_ff;

endmodule
`default_nettype wire

// ===== rtl/core/kdht_update.sv =====
`default_nettype none
module kdht_update import kdht_pkg::*; #(
   parameter int TIME_BITS = KDHT_TIME_BITS
) (
   input  wire logic [2:0]           phase,
   input  wire logic [TIME_BITS-1:0] press_stamp,
   input  wire logic [TIME_BITS-1:0] release_stamp,
   input  wire logic                 raw,
   input  wire logic [TIME_BITS-1:0] now,
   input  wire kdht_cfg_type         cfg,
   output      logic [2:0]           next_phase,
   output      logic [TIME_BITS-1:0] next_press_stamp,
   output      logic [TIME_BITS-1:0] next_release_stamp,
   output      kdht_flags_type       flags
);

   localparam int CMP_W = (TIME_BITS > 24) ? TIME_BITS : 24;

   logic                 use_release;
   logic                 use_debounce;
   logic [TIME_BITS-1:0] stamp_sel;
   logic [23:0]          thr_sel;
   logic [TIME_BITS-1:0] elapsed;
   logic                 reached;
   logic                 press_ev;
   logic                 release_ev;
   logic [2:0]           ph;

   // one shared elapsed-time compare: the stamp and threshold follow the phase
   assign use_release  = (phase == PH_DEB_RELEASE) && !raw;
   assign use_debounce = (phase == PH_DEB_PRESS) || use_release;
   assign stamp_sel    = use_release ? release_stamp : press_stamp;
   assign thr_sel      = use_debounce ? {4'd0, cfg.debounce_time} : cfg.hold_time;
   assign elapsed      = now - stamp_sel;
   assign reached      = CMP_W'(elapsed) >= CMP_W'(thr_sel);

   always_comb begin
      ph                 = phase;
      next_press_stamp   = press_stamp;
      next_release_stamp = release_stamp;
      press_ev           = 1'b0;
      release_ev         = 1'b0;
      case (phase)
         PH_DEB_PRESS: begin
            if (!raw) begin
               ph = PH_IDLE;
            end else if (reached) begin
               next_press_stamp = now;
               press_ev         = 1'b1;
               ph = (cfg.hold_time == '0) ? PH_HOLDING : PH_PRESSED;
            end
         end
         PH_PRESSED: begin
            if (!raw) begin
               ph                 = PH_DEB_RELEASE;
               next_release_stamp = now;
            end else if (reached) begin
               ph = PH_HOLDING;
            end
         end
         PH_HOLDING: begin
            if (!raw) begin
               ph                 = PH_DEB_RELEASE;
               next_release_stamp = now;
            end
         end
         PH_DEB_RELEASE: begin
            if (!raw) begin
               if (reached) begin
                  ph         = PH_IDLE;
                  release_ev = 1'b1;
               end
            end else begin
               // bounce back: hold still counts from the confirmed press
               ph = reached ? PH_HOLDING : PH_PRESSED;
            end
         end
         default: begin
            if (raw) begin
               ph               = PH_DEB_PRESS;
               next_press_stamp = now;
            end else begin
               ph = PH_IDLE;
            end
         end
      endcase
   end

   assign next_phase          = ph;
   assign flags.key_phase     = ph;
   assign flags.is_down       = (ph == PH_PRESSED) || (ph == PH_HOLDING);
   assign flags.is_holding    = (ph == PH_HOLDING);
   assign flags.press_event   = press_ev;
   assign flags.release_event = release_ev;

endmodule
`default_nettype wire

// ===== rtl/core/keypad_debounce_hold_tracker.sv =====
`default_nettype none
// Keypad debounce and hold tracker: each request transaction carries one raw
// sample of one key and yields exactly one response transaction with that
// key's new phase, down/held flags and one-shot press/release events. Key
// state (phase, press stamp, release stamp) lives in a single table of
// MAX_ROWS*MAX_COLS entries, read on acceptance and written back from the
// update stage; a write to the key just read is forwarded, so samples of the
// same key may follow each other in consecutive cycles. Throughput is one
// transaction per clock while responses are not stalled; a request passes
// the table read register and the update/write-back stage to the response
// register. Per-entry valid flops clear at reset, so the table is usable
// after reset with no clearing pass. Configuration writes take effect on the
// next clock and are meant to be made while no transaction is in flight.
module keypad_debounce_hold_tracker import kdht_pkg::*; #(
   parameter int MAX_ROWS  = KDHT_MAX_ROWS,
   parameter int MAX_COLS  = KDHT_MAX_COLS,
   parameter int TIME_BITS = KDHT_TIME_BITS
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output      logic                       req_stall,
   input  wire logic [2:0]                 req_key_row,
   input  wire logic [3:0]                 req_key_col,
   input  wire logic                       req_raw_pressed,
   input  wire logic [31:0]                req_now_us,
   output      logic                       rsp_valid,
   input  wire logic                       rsp_stall,
   output      logic                       rsp_in_range,
   output      logic [2:0]                 rsp_key_phase,
   output      logic                       rsp_is_down,
   output      logic                       rsp_is_holding,
   output      logic                       rsp_press_event,
   output      logic                       rsp_release_event,
   input  wire logic                       csr_wr_en,
   input  wire logic [KDHT_CSR_IDX_W-1:0]  csr_index,
   input  wire logic [KDHT_CSR_DATA_W-1:0] csr_data
);

   localparam int DEPTH   = MAX_ROWS * MAX_COLS;
   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ENTRY_W = 3 + 2 * TIME_BITS;

   kdht_cfg_type cfg;

   kdht_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // request side
   logic             accept;
   logic             advance;
   logic             req_in_range;
   logic [IDX_W-1:0] req_idx;

   assign req_in_range = ({1'b0, req_key_row} < cfg.rows_in_use)
                      && (int'(req_key_row) < MAX_ROWS)
                      && ({1'b0, req_key_col} < cfg.cols_in_use)
                      && (int'(req_key_col) < MAX_COLS);
   assign req_idx = req_in_range
                  ? IDX_W'(int'(req_key_row) * MAX_COLS + int'(req_key_col)) : '0;

   // update stage
   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_in_range_ff;
   logic                 s1_raw_ff;
   logic [TIME_BITS-1:0] s1_now_ff;
   logic [IDX_W-1:0]     s1_idx_ff;

   // response register
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_in_range_ff;
   kdht_flags_type rsp_flags_ff;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_in_range_ff <= req_in_range;
         s1_raw_ff      <= req_raw_pressed;
         s1_now_ff      <= TIME_BITS'(req_now_us);
         s1_idx_ff      <= req_idx;
      end
   end

   // state table
   logic [ENTRY_W-1:0]   rd_data;
   logic                 rd_valid;
   logic                 wr_en;
   logic [ENTRY_W-1:0]   wr_data;
   logic [2:0]           cur_phase;
   logic [2:0]           next_phase;
   logic [TIME_BITS-1:0] next_press_stamp;
   logic [TIME_BITS-1:0] next_release_stamp;
   kdht_flags_type       flags;

   assign wr_en   = s1_valid_ff && advance && s1_in_range_ff;
   assign wr_data = {next_phase, next_press_stamp, next_release_stamp};

   kdht_table #(
      .DEPTH  (DEPTH),
      .IDX_W  (IDX_W),
      .DATA_W (ENTRY_W)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_idx   (req_idx),
      .rd_data  (rd_data),
      .rd_valid (rd_valid),
      .wr_en    (wr_en),
      .wr_idx   (s1_idx_ff),
      .wr_data  (wr_data)
   );

   assign cur_phase = rd_valid ? rd_data[ENTRY_W-1 -: 3] : PH_IDLE;

   kdht_update #(
      .TIME_BITS (TIME_BITS)
   ) u_update (
      .phase              (cur_phase),
      .press_stamp        (rd_data[2*TIME_BITS-1 -: TIME_BITS]),
      .release_stamp      (rd_data[TIME_BITS-1:0]),
      .raw                (s1_raw_ff),
      .now                (s1_now_ff),
      .cfg                (cfg),
      .next_phase         (next_phase),
      .next_press_stamp   (next_press_stamp),
      .next_release_stamp (next_release_stamp),
      .flags              (flags)
   );

   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         rsp_in_range_ff <= s1_in_range_ff;
         rsp_flags_ff    <= s1_in_range_ff ? flags : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_in_range      = rsp_in_range_ff;
   assign rsp_key_phase     = rsp_flags_ff.key_phase;
   assign rsp_is_down       = rsp_flags_ff.is_down;
   assign rsp_is_holding    = rsp_flags_ff.is_holding;
   assign rsp_press_event   = rsp_flags_ff.press_event;
   assign rsp_release_event = rsp_flags_ff.release_event;

endmodule
`default_nettype wire

// ===== rtl/core/kdht_checker.sv =====
`default_nettype none
`include "keypad_debounce_hold_tracker_defines.svh"
module kdht_checker import kdht_pkg::*; (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic       rsp_in_range,
   input wire logic [2:0] rsp_key_phase,
   input wire logic       rsp_is_down,
   input wire logic       rsp_is_holding,
   input wire logic       rsp_press_event,
   input wire logic       rsp_release_event
);

   // stalled response transaction stays put
   `KDHT_ASSERT_NEXT(rsp_hold_a, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_key_phase) && $stable(rsp_press_event) && $stable(rsp_release_event))

   // out-of-range key reports nothing
   `KDHT_ASSERT(out_of_range_a, !(rsp_valid && !rsp_in_range) || (rsp_key_phase == PH_IDLE && !rsp_is_down && !rsp_is_holding && !rsp_press_event && !rsp_release_event))

   // flags agree with the phase
   `KDHT_ASSERT(flags_a, !rsp_valid || ((rsp_is_down == (rsp_key_phase == PH_PRESSED || rsp_key_phase == PH_HOLDING)) && (rsp_is_holding == (rsp_key_phase == PH_HOLDING))))

   // events land in the phase they confirm, never together
   `KDHT_ASSERT(events_a, !rsp_valid || ((!rsp_press_event || rsp_is_down) && (!rsp_release_event || (rsp_key_phase == PH_IDLE && !rsp_press_event))))

endmodule

bind keypad_debounce_hold_tracker kdht_checker u_kdht_checker (.*);
`default_nettype wire

// ===== tb/sv/testbench.sv =====
module testbench;
   import kdht_pkg::*;

   localparam int KEY_SLOTS = KDHT_MAX_ROWS * KDHT_MAX_COLS;

   typedef struct packed {
      logic [2:0]  row;
      logic [3:0]  col;
      logic        raw_pressed;
      logic [31:0] now_us;
   } key_sample_type;

   typedef struct packed {
      logic       in_range;
      logic [2:0] key_phase;
      logic       is_down;
      logic       is_holding;
      logic       press_event;
      logic       release_event;
   } key_outcome_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [2:0]                 req_key_row = '0;
   logic [3:0]                 req_key_col = '0;
   logic                       req_raw_pressed = 1'b0;
   logic [31:0]                req_now_us = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic                       rsp_in_range;
   logic [2:0]                 rsp_key_phase;
   logic                       rsp_is_down;
   logic                       rsp_is_holding;
   logic                       rsp_press_event;
   logic                       rsp_release_event;
   logic                       csr_wr_en = 1'b0;
   logic [KDHT_CSR_IDX_W-1:0]  csr_index = '0;
   logic [KDHT_CSR_DATA_W-1:0] csr_data = '0;

   keypad_debounce_hold_tracker DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_key_row       (req_key_row),
      .req_key_col       (req_key_col),
      .req_raw_pressed   (req_raw_pressed),
      .req_now_us        (req_now_us),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_in_range      (rsp_in_range),
      .rsp_key_phase     (rsp_key_phase),
      .rsp_is_down       (rsp_is_down),
      .rsp_is_holding    (rsp_is_holding),
      .rsp_press_event   (rsp_press_event),
      .rsp_release_event (rsp_release_event),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #4 clock = ~clock;

   // predictor state
   kdht_cfg_type   tracker_cfg;
   kdht_phase_type phase_mem [KEY_SLOTS];
   logic [31:0]    press_stamp_mem [KEY_SLOTS];
   logic [31:0]    release_stamp_mem [KEY_SLOTS];

   key_sample_type  pending_samples [$];
   key_outcome_type expected_outcomes [$];

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   bit          req_taken = 1'b0;

   int mismatch_count = 0;
   int accepted_samples = 0;
   int settings_used = 1;
   int press_seen = 0;
   int release_seen = 0;
   int holding_seen = 0;
   int outside_seen = 0;

   function automatic key_outcome_type track_key_sample(key_sample_type s);
      key_outcome_type o;
      kdht_phase_type  ph;
      int unsigned     slot;
      logic [31:0]     since_press;
      logic [31:0]     since_release;
      o = '0;
      if (s.row >= tracker_cfg.rows_in_use || s.col >= tracker_cfg.cols_in_use)
         return o;
      slot = s.row * KDHT_MAX_COLS + s.col;
      ph = phase_mem[slot];
      since_press = s.now_us - press_stamp_mem[slot];
      since_release = s.now_us - release_stamp_mem[slot];
      case (ph)
         PH_DEB_PRESS: begin
            if (!s.raw_pressed) begin
               ph = PH_IDLE;
            end else if (since_press >= tracker_cfg.debounce_time) begin
               press_stamp_mem[slot] = s.now_us;
               o.press_event = 1'b1;
               if (tracker_cfg.hold_time == 0) ph = PH_HOLDING;
               else ph = PH_PRESSED;
            end
         end
         PH_PRESSED: begin
            if (!s.raw_pressed) begin
               ph = PH_DEB_RELEASE;
               release_stamp_mem[slot] = s.now_us;
            end else if (since_press >= tracker_cfg.hold_time) begin
               ph = PH_HOLDING;
            end
         end
         PH_HOLDING: begin
            if (!s.raw_pressed) begin
               ph = PH_DEB_RELEASE;
               release_stamp_mem[slot] = s.now_us;
            end
         end
         PH_DEB_RELEASE: begin
            // a re-press goes straight back, hold measured from the original press
            if (s.raw_pressed) begin
               if (since_press >= tracker_cfg.hold_time) ph = PH_HOLDING;
               else ph = PH_PRESSED;
            end else if (since_release >= tracker_cfg.debounce_time) begin
               ph = PH_IDLE;
               o.release_event = 1'b1;
            end
         end
         default: begin
            if (s.raw_pressed) begin
               ph = PH_DEB_PRESS;
               press_stamp_mem[slot] = s.now_us;
            end else begin
               ph = PH_IDLE;
            end
         end
      endcase
      phase_mem[slot] = ph;
      o.in_range = 1'b1;
      o.key_phase = ph;
      o.is_down = (ph == PH_PRESSED || ph == PH_HOLDING);
      o.is_holding = (ph == PH_HOLDING);
      return o;
   endfunction

   function automatic void check_field(string name, logic [2:0] want, logic [2:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // request side: take over a transaction once accepted, otherwise hold it
   always @(negedge clock) begin : drive_samples
      key_sample_type s;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            s = pending_samples.pop_front();
            req_key_row <= s.row;
            req_key_col <= s.col;
            req_raw_pressed <= s.raw_pressed;
            req_now_us <= s.now_us;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= !reset && ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin : watch_ports
      key_outcome_type want;
      req_taken = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            want = track_key_sample({req_key_row, req_key_col, req_raw_pressed, req_now_us});
            expected_outcomes.push_back(want);
            accepted_samples++;
            press_seen += int'(want.press_event);
            release_seen += int'(want.release_event);
            holding_seen += int'(want.is_holding);
            outside_seen += int'(!want.in_range);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_outcomes.size() == 0) begin
               $error("response transaction with no sample outstanding");
               mismatch_count++;
            end else begin
               want = expected_outcomes.pop_front();
               check_field("in_range", 3'(want.in_range), 3'(rsp_in_range));
               check_field("key_phase", want.key_phase, rsp_key_phase);
               check_field("is_down", 3'(want.is_down), 3'(rsp_is_down));
               check_field("is_holding", 3'(want.is_holding), 3'(rsp_is_holding));
               check_field("press_event", 3'(want.press_event), 3'(rsp_press_event));
               check_field("release_event", 3'(want.release_event),
                           3'(rsp_release_event));
            end
         end
      end
   end

   task automatic queue_sample(logic [2:0] r, logic [3:0] c, logic raw, logic [31:0] t);
      pending_samples.push_back({r, c, raw, t});
   endtask

   task automatic wait_until_drained();
      while (pending_samples.size() != 0 || req_valid || expected_outcomes.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_csr(kdht_csr_index_type idx, logic [KDHT_CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      case (idx)
         CSR_DEBOUNCE_TIME: tracker_cfg.debounce_time = value[19:0];
         CSR_HOLD_TIME:     tracker_cfg.hold_time = value[23:0];
         CSR_ROWS_IN_USE:   tracker_cfg.rows_in_use = value[3:0];
         CSR_COLS_IN_USE:   tracker_cfg.cols_in_use = value[4:0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin : run_phases
      logic [19:0] deb;
      logic [23:0] hold;
      logic [3:0]  rows;
      logic [4:0]  cols;
      logic [23:0] junk;
      logic [31:0] sample_clock_us;
      logic [31:0] gap_us;
      logic [2:0]  busy_row [4];
      logic [3:0]  busy_col [4];
      bit          busy_level [4];
      int          eff_rows;
      int          eff_cols;
      int          count;
      int          k;

      tracker_cfg.debounce_time = KDHT_DEBOUNCE_RESET;
      tracker_cfg.hold_time = KDHT_HOLD_RESET;
      tracker_cfg.rows_in_use = KDHT_ROWS_RESET;
      tracker_cfg.cols_in_use = KDHT_COLS_RESET;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         phase_mem[i] = PH_IDLE;
         press_stamp_mem[i] = '0;
         release_stamp_mem[i] = '0;
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 17;
      recv_stall_pct = 79;

      // directed walk under reset settings: 5000 us debounce, 500000 us hold
      queue_sample(3'd0, 4'd0, 1'b1, 32'd100);
      queue_sample(3'd0, 4'd0, 1'b1, 32'd200);
      queue_sample(3'd0, 4'd0, 1'b1, 32'd5100);       // press confirmed
      queue_sample(3'd0, 4'd0, 1'b1, 32'd5200);
      queue_sample(3'd0, 4'd0, 1'b0, 32'd6000);       // release debounce
      queue_sample(3'd0, 4'd0, 1'b1, 32'd6100);       // re-press before hold
      queue_sample(3'd0, 4'd0, 1'b1, 32'd505100);     // exactly hold time
      queue_sample(3'd0, 4'd0, 1'b0, 32'd505200);
      queue_sample(3'd0, 4'd0, 1'b1, 32'd505300);     // re-press after hold
      queue_sample(3'd0, 4'd0, 1'b0, 32'd505400);
      queue_sample(3'd0, 4'd0, 1'b0, 32'd510400);     // release confirmed
      // timestamp wrap on the last key
      queue_sample(3'd7, 4'd15, 1'b1, 32'hFFFF_F000);
      queue_sample(3'd7, 4'd15, 1'b1, 32'h0000_0388);
      queue_sample(3'd7, 4'd15, 1'b0, 32'h0000_1000);
      queue_sample(3'd7, 4'd15, 1'b0, 32'h0000_2387);
      queue_sample(3'd7, 4'd15, 1'b0, 32'h0000_2388);
      // let go during press debounce
      queue_sample(3'd3, 4'd5, 1'b1, 32'h0000_3000);
      queue_sample(3'd3, 4'd5, 1'b0, 32'h0000_3001);
      queue_sample(3'd3, 4'd5, 1'b0, 32'h0000_9000);
      queue_sample(3'd1, 4'd10, 1'b1, 32'hFFFF_FFFF);
      queue_sample(3'd1, 4'd10, 1'b1, 32'h0000_1387);
      queue_sample(3'd1, 4'd10, 1'b0, 32'h7FFF_FFFF);
      queue_sample(3'd6, 4'd9, 1'b0, 32'h8000_0000);
      wait_until_drained();

      sample_clock_us = $urandom();
      for (int phase_no = 1; phase_no <= 9; phase_no++) begin
         case (phase_no)
            1: begin
               deb = '0; hold = '0; rows = 4'd15; cols = 5'd31; count = 100;
            end
            2: begin
               deb = '1; hold = '1; rows = 4'd8; cols = 5'd16; count = 80;
            end
            4: begin
               deb = 20'($urandom_range(50)); hold = 24'($urandom_range(400));
               rows = 4'd0; cols = 5'd0; count = 20;
            end
            6: begin
               deb = 20'($urandom_range(1, 300)); hold = 24'($urandom_range(3000));
               rows = 4'd1; cols = 5'd1; count = 80;
            end
            8: begin
               deb = 20'($urandom_range(1, 300)); hold = '0;
               rows = 4'd8; cols = 5'd16; count = 100;
            end
            default: begin
               deb = 20'($urandom_range(1, 300)); hold = 24'($urandom_range(3000));
               rows = 4'($urandom_range(1, 8)); cols = 5'($urandom_range(1, 16));
               count = 140;
            end
         endcase

         if (phase_no <= 3) begin
            send_idle_pct = 17; recv_stall_pct = 79;
         end else if (phase_no <= 6) begin
            send_idle_pct = 79; recv_stall_pct = 17;
         end else begin
            send_idle_pct = 0; recv_stall_pct = 0;
         end

         // junk above each register's width must be ignored
         junk = 24'($urandom());
         write_csr(CSR_DEBOUNCE_TIME, {junk[23:20], deb});
         write_csr(CSR_HOLD_TIME, hold);
         junk = 24'($urandom());
         write_csr(CSR_ROWS_IN_USE, {junk[23:4], rows});
         write_csr(CSR_COLS_IN_USE, {junk[23:5], cols});
         settings_used++;

         eff_rows = (rows > KDHT_MAX_ROWS) ? KDHT_MAX_ROWS : rows;
         eff_cols = (cols > KDHT_MAX_COLS) ? KDHT_MAX_COLS : cols;
         for (int i = 0; i < 4; i++) begin
            busy_row[i] = (eff_rows == 0) ? 3'd0 : 3'($urandom_range(eff_rows - 1));
            busy_col[i] = (eff_cols == 0) ? 4'd0 : 4'($urandom_range(eff_cols - 1));
            busy_level[i] = 1'b0;
         end

         // mostly press/hold/release episodes on a few keys with contact bounce
         for (int n = 0; n < count; n++) begin
            case ($urandom_range(9))
               0, 1, 2, 3, 4: gap_us = $urandom_range(deb / 2 + 1);
               5, 6, 7:       gap_us = $urandom_range(deb + hold / 3 + 1);
               8:             gap_us = $urandom_range(deb + hold + 1);
               default:       gap_us = $urandom();
            endcase
            sample_clock_us += gap_us;
            if (eff_rows == 0 || eff_cols == 0 || $urandom_range(99) < 15) begin
               queue_sample(3'($urandom_range(7)), 4'($urandom_range(15)),
                            1'($urandom_range(1)), sample_clock_us);
            end else begin
               k = $urandom_range(3);
               if ($urandom_range(5) == 0) busy_level[k] = !busy_level[k];
               queue_sample(busy_row[k], busy_col[k],
                            busy_level[k] ^ ($urandom_range(9) == 0), sample_clock_us);
            end
         end
         wait_until_drained();
      end

      repeat (4) @(posedge clock);
      $display("Ran %0d key samples under %0d register settings, idle and stall mixes.",
               accepted_samples, settings_used);
      $display("Saw %0d presses, %0d releases, %0d holding and %0d out-of-range results.",
               press_seen, release_seen, holding_seen, outside_seen);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("Mismatches found");
      $finish;
   end

endmodule
